// ===== design/assert_macros.svh =====
// Assertion macros for the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/anc_pkg.sv =====
// Shared types, constants and level functions of the A-law codec.
package anc_pkg;

  // Command codes
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // Even-bit inversion applied to every code
  localparam logic [7:0] INV_MASK = 8'h55;

  // Magnitude biases for segment zero and for the upper segments
  localparam logic [14:0] SEG0_BIAS = 15'h008;
  localparam logic [14:0] SEG_BIAS  = 15'h108;

  typedef struct packed {
    logic               command;
    logic        [7:0]  code_in;
    logic signed [15:0] sample_in;
  } anc_in_t;

  typedef struct packed {
    logic        [7:0]  code_out;
    logic signed [15:0] level_out;
  } anc_out_t;

  // Magnitude of an inverted code's low seven bits (segment, mantissa)
  function automatic logic [14:0] anc_mag(input logic [6:0] a);
    logic [2:0]  seg;
    logic [14:0] base;
    seg  = a[6:4];
    base = {7'd0, a[3:0], 4'd0};
    if (seg == 3'd0) begin
      anc_mag = base + SEG0_BIAS;
    end else begin
      anc_mag = (base + SEG_BIAS) << (seg - 3'd1);
    end
  endfunction

  // Signed linear level of a code byte
  function automatic logic signed [15:0] anc_expand(input logic [7:0] code);
    logic [7:0]  a;
    logic [15:0] lvl;
    a   = code ^ INV_MASK;
    lvl = {1'b0, anc_mag(a[6:0])};
    anc_expand = a[7] ? lvl : (16'd0 - lvl);
  endfunction

endpackage

// ===== design/alaw_nearest_codec.sv =====
// Top level of the A-law codec: input register, decode/encode logic, result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | start, busy (always 0)  | in_item  : command, code_in, sample_in
//  result   | out_strobe (one cycle)  | out_item : code_out, level_out
//
// One item per cycle; an accepted item passes through the input register, the search
// logic and the result register before it is strobed out.
// Synchronous active-low reset clears both valid flags; payloads are not reset.
// The result side cannot stall, so busy never rises and nothing is held back.
module alaw_nearest_codec import anc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  anc_in_t  in_item,
  output logic     out_strobe,
  output anc_out_t out_item
);

`include "assert_macros.svh"

  logic     in_vld_r;
  logic     in_vld_nxt;
  anc_in_t  in_item_r;
  logic     out_strobe_r;
  anc_out_t out_item_r;
  anc_out_t out_item_nxt;
  anc_out_t enc_result;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register
  assign in_vld_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

  // Nearest-code search
  anc_encoder u_encoder (
    .sample (in_item_r.sample_in),
    .result (enc_result)
  );

  // Decode echoes the code; encode takes the search result
  always_comb begin
    if (in_item_r.command == CMD_ENCODE) begin
      out_item_nxt = enc_result;
    end else begin
      out_item_nxt.code_out  = in_item_r.code_in;
      out_item_nxt.level_out = anc_expand(in_item_r.code_in);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Every accepted item is held in the input register the next cycle
  `ASSERT_NEXT(a_in_hold, clk, rst_n, accept, in_vld_r)
  // A held input item is strobed out the next cycle
  `ASSERT_NEXT(a_latency, clk, rst_n, in_vld_r, out_strobe_r)
  // A result only follows a held input item
  `ASSERT_NEXT(a_no_phantom, clk, rst_n, !in_vld_r, !out_strobe_r)
  // Decode echoes the held code
  `ASSERT_NEXT(a_decode_echo, clk, rst_n,
    in_vld_r && (in_item_r.command == CMD_DECODE),
    out_item_r.code_out == $past(in_item_r.code_in))
  // Encode of a non-negative sample yields a positive level
  `ASSERT_NEXT(a_encode_sign, clk, rst_n,
    in_vld_r && (in_item_r.command == CMD_ENCODE) && !in_item_r.sample_in[15],
    !out_item_r.level_out[15])

endmodule

// ===== design/anc_encoder.sv =====
// Nearest-code search: clamp, segment priority, two-candidate compare.
module anc_encoder import anc_pkg::*; (
  input  logic signed [15:0] sample,
  output anc_out_t           result
);

  localparam logic signed [15:0] FULL_SCALE = 16'sd32256;

  // First level of each segment
  localparam logic [14:0] SEG_BASE [8] = '{
    15'd8, 15'd264, 15'd528, 15'd1056, 15'd2112, 15'd4224, 15'd8448, 15'd16896
  };

  logic signed [15:0] clamped;
  logic               pos;
  logic [14:0]        x;
  logic [2:0]         seg;
  logic               below;
  logic [3:0]         sh;
  logic [14:0]        diff;
  logic [14:0]        m_raw;
  logic [3:0]         m;
  logic [6:0]         lo_idx;
  logic [6:0]         hi_idx;
  logic               has_hi;
  logic [14:0]        lo_mag;
  logic [14:0]        hi_mag;
  logic [14:0]        d_lo;
  logic [14:0]        d_hi;
  logic [7:0]         code_lo;
  logic [7:0]         code_hi;
  logic               pick_hi;
  logic [14:0]        mag;
  logic [15:0]        lvl;

  // Clamp to full scale, split into sign and magnitude; zero counts as positive
  always_comb begin
    if (sample > FULL_SCALE) begin
      clamped = FULL_SCALE;
    end else if (sample < -FULL_SCALE) begin
      clamped = -FULL_SCALE;
    end else begin
      clamped = sample;
    end
    pos = !clamped[15];
    x   = pos ? clamped[14:0] : 15'(16'd0 - clamped);
  end

  // Segment priority: highest segment whose first level is not above x
  always_comb begin
    seg = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (x >= SEG_BASE[k]) begin
        seg = 3'(k);
      end
    end
    below = (x < SEG_BASE[0]);
  end

  // Mantissa of the level at or below x; gap above a segment's last level clamps
  always_comb begin
    sh    = (seg == 3'd0) ? 4'd4 : ({1'b0, seg} + 4'd3);
    diff  = x - SEG_BASE[seg];
    m_raw = diff >> sh;
    m     = (m_raw > 15'd15) ? 4'd15 : m_raw[3:0];
  end

  // Candidates on either side of x
  always_comb begin
    lo_idx  = below ? 7'd0 : {seg, m};
    hi_idx  = lo_idx + 7'd1;
    has_hi  = !below && (lo_idx != 7'h7F);
    lo_mag  = anc_mag(lo_idx);
    hi_mag  = anc_mag(hi_idx);
    d_lo    = x - lo_mag;
    d_hi    = hi_mag - x;
    code_lo = {pos, lo_idx} ^ INV_MASK;
    code_hi = {pos, hi_idx} ^ INV_MASK;
    // nearer wins; equal distance goes to the lower code number
    pick_hi = has_hi && ((d_hi < d_lo) || ((d_hi == d_lo) && (code_hi < code_lo)));
  end

  // Result from the chosen candidate
  always_comb begin
    mag              = pick_hi ? hi_mag : lo_mag;
    lvl              = {1'b0, mag};
    result.code_out  = pick_hi ? code_hi : code_lo;
    result.level_out = pos ? lvl : (16'd0 - lvl);
  end

endmodule
